>>> hdl/tfdt_pkg.sv
// Package for the TCP flow direction tracker: field widths, handshake and
// register codes, and the token that travels down the chain of flow cells.
// No dependencies.
package tfdt_pkg;

  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int EP_W       = ADDR_W + PORT_W;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_SVC    = 5;

  typedef logic [EP_W-1:0]   endpoint_t;
  typedef logic [PORT_W-1:0] port_t;

  // Handshake classes of an input item; the unused code counts as none.
  localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SYN     = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_SYN_ACK = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SVC_PORT_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SVC_PORT_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SVC_PORT_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SVC_PORT_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SVC_PORT_E = 3'd4;

  localparam port_t SVC_PORT_A_RST = 16'd502;
  localparam port_t SVC_PORT_B_RST = 16'd20000;
  localparam port_t SVC_PORT_C_RST = 16'd102;
  localparam port_t SVC_PORT_D_RST = 16'd2404;
  localparam port_t SVC_PORT_E_RST = 16'd44818;

  typedef port_t [NUM_SVC-1:0] svc_ports_t;

  // One packet on its way through the flow table.
  typedef struct packed {
    logic      vld;          // stage holds a packet
    logic      tcp;          // packet is IP and TCP
    logic      done;         // a cell has already matched or stored the flow
    endpoint_t src_ep;
    endpoint_t dst_ep;
    logic      hs_any;       // SYN or SYN-ACK
    logic      hs_syn;       // SYN only
    logic      ep_eq;        // source and destination endpoints are equal
    logic      new_src_cli;  // direction a new flow would get
    logic      res_sic;      // source is client, once done
    logic      res_hand;     // direction from handshake, once done
  } token_t;

endpackage

>>> hdl/tfdt_if.sv
// Channel interfaces of the TCP flow direction tracker: packet headers in,
// direction results out. Depends on tfdt_pkg for field widths.
interface tfdt_in_if;
  logic                             valid;
  logic                             ready;
  logic                             is_ip_tcp;
  logic [tfdt_pkg::ADDR_W-1:0]      source_addr;
  logic [tfdt_pkg::PORT_W-1:0]      source_port;
  logic [tfdt_pkg::ADDR_W-1:0]      dest_addr;
  logic [tfdt_pkg::PORT_W-1:0]      dest_port;
  logic [tfdt_pkg::CLASS_W-1:0]     handshake_class;

  modport source (output valid, is_ip_tcp, source_addr, source_port, dest_addr,
                  dest_port, handshake_class, input ready);
  modport sink   (input valid, is_ip_tcp, source_addr, source_port, dest_addr,
                  dest_port, handshake_class, output ready);
endinterface

interface tfdt_out_if;
  logic valid;
  logic ready;
  logic direction_valid;
  logic source_is_client;
  logic from_handshake;
  logic not_stored;

  modport source (output valid, direction_valid, source_is_client, from_handshake,
                  not_stored, input ready);
  modport sink   (input valid, direction_valid, source_is_client, from_handshake,
                  not_stored, output ready);
endinterface

>>> hdl/tcp_flow_direction_tracker.sv
// Top level of the TCP flow direction tracker: service port registers, the
// entry stage, the chain of flow cells and the result register.
// Depends on tfdt_pkg, tfdt_if, tfdt_head and tfdt_cell.
//
// Usage: packet headers arrive on in_ch, one per valid/ready transfer, and
// each produces exactly one result transfer on out_ch, in the same order.
// A packet passes the entry stage, then each flow cell in turn, and then the
// result register, which offers it on out_ch. The chain is a pipeline: one
// header can be taken every cycle while out_ch takes results, so the
// sustained rate is one item per cycle. When out_ch stalls, the result
// register holds its item and the whole chain freezes; in_ch.ready drops in
// the same cycle.
// Packets that are not IP and TCP pass through with an all-zero result.
// Reset empties the flow table and loads the default service ports; no
// clearing pass is needed. The cfg_ port writes a service port register at
// any clock edge with cfg_we high, and is meant to be used while the block
// holds no packets.
module tcp_flow_direction_tracker #(
  parameter int FLOW_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tfdt_in_if.sink                            in_ch,
  tfdt_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [tfdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfdt_pkg::PORT_W-1:0]        cfg_data
);
  import tfdt_pkg::*;

  svc_ports_t svc_r;
  token_t     tok [0:FLOW_ENTRIES];
  token_t     tail;
  logic       adv;

  logic out_vld_r;
  logic dir_vld_r;
  logic sic_r;
  logic hand_r;
  logic nst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svc_r[CFG_SVC_PORT_A] <= SVC_PORT_A_RST;
      svc_r[CFG_SVC_PORT_B] <= SVC_PORT_B_RST;
      svc_r[CFG_SVC_PORT_C] <= SVC_PORT_C_RST;
      svc_r[CFG_SVC_PORT_D] <= SVC_PORT_D_RST;
      svc_r[CFG_SVC_PORT_E] <= SVC_PORT_E_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SVC_PORT_A: svc_r[CFG_SVC_PORT_A] <= cfg_data;
        CFG_SVC_PORT_B: svc_r[CFG_SVC_PORT_B] <= cfg_data;
        CFG_SVC_PORT_C: svc_r[CFG_SVC_PORT_C] <= cfg_data;
        CFG_SVC_PORT_D: svc_r[CFG_SVC_PORT_D] <= cfg_data;
        CFG_SVC_PORT_E: svc_r[CFG_SVC_PORT_E] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv = !out_vld_r || out_ch.ready;

  tfdt_head u_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .svc_ports (svc_r),
    .in_ch     (in_ch),
    .tok_o     (tok[0])
  );

  for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
    tfdt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  assign tail = tok[FLOW_ENTRIES];

  // A flow that found neither a match nor a free entry is answered with the
  // direction it would have been stored with.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_vld_r <= tail.tcp;
      sic_r     <= tail.tcp && (tail.done ? tail.res_sic
                                          : (tail.new_src_cli | tail.ep_eq));
      hand_r    <= tail.tcp && (tail.done ? tail.res_hand : tail.hs_any);
      nst_r     <= tail.tcp && !tail.done;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.direction_valid  = dir_vld_r;
  assign out_ch.source_is_client = sic_r;
  assign out_ch.from_handshake   = hand_r;
  assign out_ch.not_stored       = nst_r;

endmodule

>>> hdl/tfdt_head.sv
// Entry stage of the flow chain: takes a packet header transfer, classifies
// the handshake, applies the service port rule and builds the first token.
// Depends on tfdt_pkg and tfdt_in_if.
module tfdt_head (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  tfdt_pkg::svc_ports_t svc_ports,
  tfdt_in_if.sink              in_ch,
  output tfdt_pkg::token_t     tok_o
);
  import tfdt_pkg::*;

  token_t    tok_r;
  token_t    tok_nxt;
  endpoint_t src_ep;
  endpoint_t dst_ep;
  logic      sport_svc;
  logic      dport_svc;
  logic      port_src_cli;
  logic      hs_syn;
  logic      hs_ack;

  assign in_ch.ready = adv;

  always_comb begin
    src_ep = {in_ch.source_addr, in_ch.source_port};
    dst_ep = {in_ch.dest_addr, in_ch.dest_port};
    sport_svc = 1'b0;
    dport_svc = 1'b0;
    for (int k = 0; k < NUM_SVC; k++) begin
      sport_svc = sport_svc | (in_ch.source_port == svc_ports[k]);
      dport_svc = dport_svc | (in_ch.dest_port == svc_ports[k]);
    end
    // A known port on one side only marks the server; otherwise the higher
    // port is the client.
    if (dport_svc && !sport_svc) begin
      port_src_cli = 1'b1;
    end else if (sport_svc && !dport_svc) begin
      port_src_cli = 1'b0;
    end else begin
      port_src_cli = in_ch.source_port > in_ch.dest_port;
    end
    hs_syn = in_ch.handshake_class == CLASS_SYN;
    hs_ack = in_ch.handshake_class == CLASS_SYN_ACK;

    tok_nxt             = '0;
    tok_nxt.vld         = in_ch.valid;
    tok_nxt.tcp         = in_ch.is_ip_tcp;
    tok_nxt.done        = 1'b0;
    tok_nxt.src_ep      = src_ep;
    tok_nxt.dst_ep      = dst_ep;
    tok_nxt.hs_any      = hs_syn | hs_ack;
    tok_nxt.hs_syn      = hs_syn;
    tok_nxt.ep_eq       = src_ep == dst_ep;
    tok_nxt.new_src_cli = (hs_syn | hs_ack) ? hs_syn : port_src_cli;
    tok_nxt.res_sic     = 1'b0;
    tok_nxt.res_hand    = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

>>> hdl/tfdt_cell.sv
// One flow table entry of the chain. It compares the passing packet with its
// flow, stores a new flow when it is the first free entry, upgrades a port
// guess on a handshake, and hands the token on. Depends on tfdt_pkg.
module tfdt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  tfdt_pkg::token_t tok_i,
  output tfdt_pkg::token_t tok_o
);
  import tfdt_pkg::*;

  logic      used_r;
  logic      used_nxt;
  endpoint_t cli_r;
  endpoint_t cli_nxt;
  endpoint_t srv_r;
  endpoint_t srv_nxt;
  logic      hs_r;
  logic      hs_nxt;
  token_t    tok_r;
  token_t    tok_nxt;

  logic act;
  logic c_s, s_d, c_d, s_s;
  logic hit;
  logic upgrade;
  logic insert;

  always_comb begin
    act     = tok_i.vld && tok_i.tcp && !tok_i.done;
    c_s     = cli_r == tok_i.src_ep;
    s_d     = srv_r == tok_i.dst_ep;
    c_d     = cli_r == tok_i.dst_ep;
    s_s     = srv_r == tok_i.src_ep;
    hit     = act && used_r && ((c_s && s_d) || (c_d && s_s));
    upgrade = hit && !hs_r && tok_i.hs_any;
    // Entries are never released, so the used ones form a prefix and the
    // first free entry reached is the lowest one.
    insert  = act && !used_r;

    tok_nxt  = tok_i;
    used_nxt = used_r | insert;
    cli_nxt  = cli_r;
    srv_nxt  = srv_r;
    hs_nxt   = hs_r;

    if (insert) begin
      cli_nxt          = tok_i.new_src_cli ? tok_i.src_ep : tok_i.dst_ep;
      srv_nxt          = tok_i.new_src_cli ? tok_i.dst_ep : tok_i.src_ep;
      hs_nxt           = tok_i.hs_any;
      tok_nxt.done     = 1'b1;
      tok_nxt.res_sic  = tok_i.new_src_cli | tok_i.ep_eq;
      tok_nxt.res_hand = tok_i.hs_any;
    end else if (hit) begin
      if (upgrade) begin
        cli_nxt = tok_i.hs_syn ? tok_i.src_ep : tok_i.dst_ep;
        srv_nxt = tok_i.hs_syn ? tok_i.dst_ep : tok_i.src_ep;
        hs_nxt  = 1'b1;
      end
      tok_nxt.done     = 1'b1;
      tok_nxt.res_sic  = upgrade ? (tok_i.hs_syn | tok_i.ep_eq) : c_s;
      tok_nxt.res_hand = upgrade | hs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      used_r <= used_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cli_r <= cli_nxt;
      srv_r <= srv_nxt;
      hs_r  <= hs_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tcp_flow_direction_tracker: a directed table of packet headers,
// then random handshakes, mid-stream traffic and noise under several service port settings.
// Depends on tfdt_pkg, the tfdt_in_if / tfdt_out_if interfaces and the tracker RTL.
module tb;
  import tfdt_pkg::*;

  localparam int FLOW_ENTRIES = 256;
  localparam int IDLE_PCT     = 26;
  localparam int MAX_SHOWN    = 40;
  localparam logic [CLASS_W-1:0] CLASS_UNUSED = 2'd3;

  typedef struct packed {
    logic               is_ip_tcp;
    logic [ADDR_W-1:0]  source_addr;
    port_t              source_port;
    logic [ADDR_W-1:0]  dest_addr;
    port_t              dest_port;
    logic [CLASS_W-1:0] hs_class;
  } header_t;

  typedef struct packed {
    logic direction_valid;
    logic source_is_client;
    logic from_handshake;
    logic not_stored;
  } direction_t;

  typedef struct packed {
    endpoint_t a_ep;
    endpoint_t b_ep;
  } flow_t;

  typedef struct {
    header_t    hdr;
    bit         typed;
    direction_t want;
  } table_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  port_t                cfg_data;

  tfdt_in_if  hdr_ch ();
  tfdt_out_if dir_ch ();

  tcp_flow_direction_tracker #(.FLOW_ENTRIES(FLOW_ENTRIES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (hdr_ch),
    .out_ch   (dir_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state: service ports and the flow table.
  svc_ports_t svc_port;
  bit         flow_used    [FLOW_ENTRIES];
  endpoint_t  flow_client  [FLOW_ENTRIES];
  endpoint_t  flow_server  [FLOW_ENTRIES];
  bit         flow_settled [FLOW_ENTRIES];

  direction_t expected_dirs [$];
  flow_t      known_flows [$];
  table_row_t dir_rows [$];
  string      field_names [4] = '{"not_stored", "from_handshake", "source_is_client",
                                  "direction_valid"};

  int  error_count = 0;
  int  results_seen = 0;
  int  headers_sent = 0;
  int  flows_stored = 0;
  int  refused_count = 0;
  int  upgrade_count = 0;
  int  settings_used = 1;
  bit  steady = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout: results stopped arriving");
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_SHOWN) $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic bit svc_known(port_t p);
    for (int i = 0; i < NUM_SVC; i++)
      if (svc_port[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  // Works out the direction result of one header and updates the flow table.
  function automatic direction_t predict_direction(header_t h);
    direction_t r;
    endpoint_t  src_ep, dst_ep, cli;
    bit         syn, syn_ack, src_cli, sk, dk, found, have_free;
    int         hit, free_slot;
    r = '0;
    if (!h.is_ip_tcp) return r;
    src_ep = {h.source_addr, h.source_port};
    dst_ep = {h.dest_addr, h.dest_port};
    syn = h.hs_class == CLASS_SYN;
    syn_ack = h.hs_class == CLASS_SYN_ACK;
    found = 1'b0;
    have_free = 1'b0;
    hit = 0;
    free_slot = 0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (flow_used[i]) begin
        if (!found && ((flow_client[i] == src_ep && flow_server[i] == dst_ep) ||
                       (flow_client[i] == dst_ep && flow_server[i] == src_ep))) begin
          found = 1'b1;
          hit = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = i;
      end
    end
    if (!found) begin
      if (syn || syn_ack) begin
        src_cli = syn;
        r.from_handshake = 1'b1;
      end else begin
        // A known port on one side only marks the server; otherwise the higher port is
        // the client, and a tie makes the destination the client.
        sk = svc_known(h.source_port);
        dk = svc_known(h.dest_port);
        if (sk != dk) src_cli = dk;
        else src_cli = h.source_port > h.dest_port;
      end
      cli = src_cli ? src_ep : dst_ep;
      if (have_free) begin
        flow_used[free_slot] = 1'b1;
        flow_client[free_slot] = cli;
        flow_server[free_slot] = src_cli ? dst_ep : src_ep;
        flow_settled[free_slot] = r.from_handshake;
        flows_stored++;
      end else begin
        r.not_stored = 1'b1;
        refused_count++;
      end
    end else begin
      if (!flow_settled[hit] && (syn || syn_ack)) begin
        flow_client[hit] = syn ? src_ep : dst_ep;
        flow_server[hit] = syn ? dst_ep : src_ep;
        flow_settled[hit] = 1'b1;
        upgrade_count++;
      end
      cli = flow_client[hit];
      r.from_handshake = flow_settled[hit];
    end
    r.direction_valid = 1'b1;
    r.source_is_client = cli == src_ep;
    return r;
  endfunction

  function automatic table_row_t row(bit tcp, logic [ADDR_W-1:0] sa, port_t sp,
                                     logic [ADDR_W-1:0] da, port_t dp,
                                     logic [CLASS_W-1:0] hs, bit typed, direction_t want);
    table_row_t r;
    r.hdr = '{tcp, sa, sp, da, dp, hs};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic port_t pick_port(int svc_pct);
    if ($urandom_range(99) < svc_pct) return svc_port[$urandom_range(NUM_SVC - 1)];
    return port_t'($urandom_range(65535));
  endfunction

  function automatic flow_t fresh_flow();
    flow_t f;
    flow_t old;
    f.a_ep = {$urandom(), pick_port(10)};
    f.b_ep = {$urandom(), pick_port(35)};
    case ($urandom_range(9))
      0: begin
        // Same hosts as an older flow, so only the ports tell the flows apart.
        if (known_flows.size() != 0) begin
          old = known_flows[$urandom_range(known_flows.size() - 1)];
          f.a_ep[EP_W-1:PORT_W] = old.a_ep[EP_W-1:PORT_W];
          f.b_ep[EP_W-1:PORT_W] = old.b_ep[EP_W-1:PORT_W];
        end
      end
      1: f.b_ep[PORT_W-1:0] = f.a_ep[PORT_W-1:0];
      2: if ($urandom_range(3) == 0) f.b_ep = f.a_ep;
      default: ;
    endcase
    return f;
  endfunction

  function automatic header_t flow_header(flow_t f, bit reverse, logic [CLASS_W-1:0] hs);
    endpoint_t s, d;
    s = reverse ? f.b_ep : f.a_ep;
    d = reverse ? f.a_ep : f.b_ep;
    return '{1'b1, s[EP_W-1:PORT_W], s[PORT_W-1:0], d[EP_W-1:PORT_W], d[PORT_W-1:0], hs};
  endfunction

  function automatic logic [CLASS_W-1:0] random_class();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return CLASS_NONE;
    if (roll < 82) return CLASS_SYN;
    if (roll < 94) return CLASS_SYN_ACK;
    return CLASS_UNUSED;
  endfunction

  // Offers one header, waits for its transfer and queues the direction it should get.
  task automatic send_header(input header_t h, input bit typed, input direction_t want);
    direction_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      hdr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    hdr_ch.valid           <= 1'b1;
    hdr_ch.is_ip_tcp       <= h.is_ip_tcp;
    hdr_ch.source_addr     <= h.source_addr;
    hdr_ch.source_port     <= h.source_port;
    hdr_ch.dest_addr       <= h.dest_addr;
    hdr_ch.dest_port       <= h.dest_port;
    hdr_ch.handshake_class <= h.hs_class;
    do @(posedge clk); while (hdr_ch.ready !== 1'b1);
    predicted = predict_direction(h);
    expected_dirs.push_back(typed ? want : predicted);
    headers_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    hdr_ch.valid <= 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input port_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    svc_port[idx] = value;
    @(negedge clk);
  endtask

  task automatic set_service_ports(input port_t pa, input port_t pb, input port_t pc,
                                   input port_t pd, input port_t pe);
    drain();
    write_reg(CFG_SVC_PORT_A, pa);
    write_reg(CFG_SVC_PORT_B, pb);
    write_reg(CFG_SVC_PORT_C, pc);
    write_reg(CFG_SVC_PORT_D, pd);
    write_reg(CFG_SVC_PORT_E, pe);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_traffic(input int n_items, input int fresh_pct, input bit fill_table);
    int      start;
    int      roll;
    flow_t   f;
    header_t h;
    start = headers_sent;
    while (headers_sent - start < n_items || (fill_table && flows_stored < FLOW_ENTRIES)) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        h = {1'b0, $urandom(), 16'($urandom()), $urandom(), 16'($urandom()), 2'($urandom())};
        send_header(h, 1'b0, '0);
      end else if (roll < 10 + fresh_pct || known_flows.size() == 0) begin
        f = fresh_flow();
        known_flows.push_back(f);
        if ($urandom_range(1)) begin
          // Full opening: SYN from the client, SYN-ACK back, then data either way.
          send_header(flow_header(f, 1'b0, CLASS_SYN), 1'b0, '0);
          send_header(flow_header(f, 1'b1, CLASS_SYN_ACK), 1'b0, '0);
          repeat ($urandom_range(1, 4))
            send_header(flow_header(f, 1'($urandom_range(1)), CLASS_NONE), 1'b0, '0);
        end else begin
          send_header(flow_header(f, 1'($urandom_range(1)), random_class()), 1'b0, '0);
        end
      end else begin
        f = known_flows[$urandom_range(known_flows.size() - 1)];
        send_header(flow_header(f, 1'($urandom_range(1)), random_class()), 1'b0, '0);
      end
    end
  endtask

  initial begin
    dir_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      dir_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    direction_t got, want;
    if (rst_n && dir_ch.valid === 1'b1 && dir_ch.ready) begin
      got = {dir_ch.direction_valid, dir_ch.source_is_client, dir_ch.from_handshake,
             dir_ch.not_stored};
      results_seen++;
      if (expected_dirs.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_dirs.pop_front();
        for (int i = 3; i >= 0; i--)
          if (got[i] !== want[i])
            report_mismatch($sformatf("result %0d: %s is %b, expected %b", results_seen,
                                      field_names[i], got[i], want[i]));
      end
    end
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_SVC_PORT_A;
    cfg_data               = '0;
    hdr_ch.valid           = 1'b0;
    hdr_ch.is_ip_tcp       = 1'b0;
    hdr_ch.source_addr     = '0;
    hdr_ch.source_port     = '0;
    hdr_ch.dest_addr       = '0;
    hdr_ch.dest_port       = '0;
    hdr_ch.handshake_class = CLASS_NONE;
    svc_port[CFG_SVC_PORT_A] = SVC_PORT_A_RST;
    svc_port[CFG_SVC_PORT_B] = SVC_PORT_B_RST;
    svc_port[CFG_SVC_PORT_C] = SVC_PORT_C_RST;
    svc_port[CFG_SVC_PORT_D] = SVC_PORT_D_RST;
    svc_port[CFG_SVC_PORT_E] = SVC_PORT_E_RST;

    // Directed headers under the reset ports. Typed results only where they are obvious.
    dir_rows.push_back(row(0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, CLASS_UNUSED,
                           1, 4'b0000));
    dir_rows.push_back(row(1, 32'h0A00_0001, 16'd40000, 32'h0A00_0002, 16'd502, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0A00_0002, 16'd502, 32'h0A00_0001, 16'd40000, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0A00_0002, 16'd502, 32'h0A00_0001, 16'd40000,
                           CLASS_SYN_ACK, 0, '0));
    dir_rows.push_back(row(1, 32'h0A00_0002, 16'd502, 32'h0A00_0001, 16'd40000, CLASS_SYN,
                           0, '0));
    dir_rows.push_back(row(1, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 16'd0, CLASS_SYN,
                           1, 4'b1110));
    dir_rows.push_back(row(1, 32'h0000_0000, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0000_0000, 16'd0, 32'hFFFF_FFFF, 16'd0, CLASS_SYN_ACK,
                           1, 4'b1010));
    dir_rows.push_back(row(1, 32'h0102_0304, 16'd1000, 32'h0506_0708, 16'd2000, CLASS_UNUSED,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0102_0304, 16'd1000, 32'h0506_0708, 16'd2000, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0102_0304, 16'd1000, 32'h0506_0708, 16'd2000, CLASS_SYN,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0506_0708, 16'd2000, 32'h0102_0304, 16'd1000, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0B00_0001, 16'd7000, 32'h0B00_0002, 16'd7000, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0B00_0001, 16'd502, 32'h0B00_0002, 16'd102, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0B00_0001, 16'd20000, 32'h0B00_0002, 16'd30000, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0B00_0001, 16'd1, 32'h0B00_0002, 16'd44818, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0B00_0001, 16'd5000, 32'h0B00_0002, 16'd2404, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0909_0909, 16'd80, 32'h0909_0909, 16'd80, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0909_0909, 16'd80, 32'h0909_0909, 16'd80, CLASS_NONE,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0A00_0001, 16'd40001, 32'h0A00_0002, 16'd502, CLASS_SYN,
                           1, 4'b1110));
    dir_rows.push_back(row(0, 32'h0000_0000, 16'd0, 32'h0000_0000, 16'd0, CLASS_NONE,
                           1, 4'b0000));
    dir_rows.push_back(row(1, 32'h0B00_0002, 16'd7000, 32'h0B00_0001, 16'd7000, CLASS_SYN_ACK,
                           0, '0));
    dir_rows.push_back(row(1, 32'h0B00_0002, 16'hFFFF, 32'h0B00_0001, 16'd0, CLASS_NONE,
                           0, '0));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_header(dir_rows[i].hdr, dir_rows[i].typed, dir_rows[i].want);
    run_traffic(360, 15, 1'b0);

    // Extreme ports, with a duplicate; the first stretch runs with no idling on either side.
    set_service_ports(16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'd0);
    steady = 1'b1;
    run_traffic(250, 15, 1'b0);
    steady = 1'b0;
    run_traffic(110, 15, 1'b0);

    // Mostly new flows until the table is full.
    set_service_ports(port_t'($urandom_range(65535)), port_t'($urandom_range(65535)),
                      port_t'($urandom_range(65535)), port_t'($urandom_range(65535)),
                      port_t'($urandom_range(65535)));
    run_traffic(360, 60, 1'b1);

    // Full table: stored flows still match, new ones are answered but refused.
    set_service_ports(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(360, 30, 1'b0);

    drain();
    repeat (FLOW_ENTRIES + 20) @(posedge clk);
    if (expected_dirs.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_dirs.size()));
    $display("Checked %0d directions for %0d headers under %0d service port settings.",
             results_seen, headers_sent, settings_used);
    $display("%0d flows stored, %0d new flows refused by the full table, %0d guesses %s",
             flows_stored, refused_count, upgrade_count, "replaced by a handshake.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
